### sv/mde_pkg.sv
// Shared constants, types and helpers for the morphology dilate/erode engine.
package mde_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_OFFSETS  = 32;
    localparam int OFFSET_RANGE = 15;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int IDX_W  = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;
    localparam int CNT_W  = 6;
    localparam int DIM_W  = 9;
    localparam int OFF_W  = 5;
    localparam int CH_W   = 8;
    localparam int NCH    = 4;
    localparam int PIX_W  = NCH * CH_W;

    localparam logic [1:0] OP_WR_PIX = 2'd0;
    localparam logic [1:0] OP_WR_OFF = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] FMT_GRAY = 2'd0;
    localparam logic [1:0] FMT_RGB  = 2'd1;

    localparam logic [2:0] REG_IMG_W  = 3'd0;
    localparam logic [2:0] REG_IMG_H  = 3'd1;
    localparam logic [2:0] REG_FORMAT = 3'd2;
    localparam logic [2:0] REG_MODE   = 3'd3;
    localparam logic [2:0] REG_OFF_N  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_NBR,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             wr_pix;
        logic             wr_off;
        logic             start_q;
        logic             rd_centre;
        logic             rd_nbr;
        logic [IDX_W-1:0] idx;
        logic             load_out;
    } cmd_t;

    typedef struct packed {
        logic             in_image;
        logic [CNT_W-1:0] n_cnt;
    } status_t;

    function automatic logic signed [OFF_W-1:0] clamp_off(input logic signed [OFF_W-1:0] v);
        logic signed [OFF_W-1:0] r;
        r = v;
        if (32'(v) > OFFSET_RANGE)
            r = OFF_W'(OFFSET_RANGE);
        else if (32'(v) < -OFFSET_RANGE)
            r = OFF_W'(-OFFSET_RANGE);
        return r;
    endfunction

endpackage

### sv/mde_ctrl.sv
// Query sequencer: walks centre pixel and offset list, hands the result to the output register.
module mde_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [1:0]      opcode,
    input  logic            out_ready,
    input  mde_pkg::status_t status,
    output logic            in_ready,
    output logic            out_valid,
    output mde_pkg::cmd_t   cmd
);
    import mde_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.idx        = idx_reg[IDX_W-1:0];
        in_ready       = (state_reg == ST_IDLE);
        accept         = in_valid && in_ready;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.wr_pix  = (opcode == OP_WR_PIX);
                    cmd.wr_off  = (opcode == OP_WR_OFF);
                    cmd.start_q = (opcode == OP_QUERY);
                    if (opcode == OP_QUERY)
                        state_next = ST_CENTRE;
                end
            end
            ST_CENTRE:
            begin
                idx_next = '0;
                if (!status.in_image)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.rd_centre = 1'b1;
                    state_next    = (status.n_cnt == '0) ? ST_DRAIN : ST_NBR;
                end
            end
            ST_NBR:
            begin
                cmd.rd_nbr = 1'b1;
                idx_next   = idx_reg + 1'b1;
                if (idx_reg == status.n_cnt - 1'b1)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### sv/mde_datapath.sv
// Frame store, offset table, neighbour address generation and max/min accumulator.
module mde_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mde_pkg::cmd_t            cmd,
    output mde_pkg::status_t         status,
    input  logic [7:0]               col,
    input  logic [7:0]               row,
    input  logic [4:0]               entry_index,
    input  logic signed [4:0]        offset_dx,
    input  logic signed [4:0]        offset_dy,
    input  logic [7:0]               in_ch0,
    input  logic [7:0]               in_ch1,
    input  logic [7:0]               in_ch2,
    input  logic [7:0]               in_ch3,
    input  logic [mde_pkg::DIM_W-1:0] image_width,
    input  logic [mde_pkg::DIM_W-1:0] image_height,
    input  logic [1:0]               pixel_format,
    input  logic                     operation_mode,
    input  logic [mde_pkg::CNT_W-1:0] offset_count,
    output logic [7:0]               out_ch0,
    output logic [7:0]               out_ch1,
    output logic [7:0]               out_ch2,
    output logic [7:0]               out_ch3
);
    import mde_pkg::*;

    logic [PIX_W-1:0]        frame_mem [2**ADDR_W];
    logic signed [OFF_W-1:0] dx_reg [MAX_OFFSETS];
    logic signed [OFF_W-1:0] dy_reg [MAX_OFFSETS];

    logic [7:0]              q_col_reg, q_row_reg;
    logic [PIX_W-1:0]        rd_data_reg;
    logic                    rd_vld_reg, rd_first_reg;
    logic [NCH-1:0][CH_W-1:0] acc_reg, acc_next;
    logic [NCH-1:0][CH_W-1:0] out_reg;

    logic [DIM_W-1:0]        w_eff, h_eff;
    logic signed [COL_W+1:0] nx;
    logic signed [ROW_W+1:0] ny;
    logic                    nbr_inside, rd_en;
    logic [ADDR_W-1:0]       rd_addr, wr_addr;
    logic [NCH-1:0]          ch_en;
    logic [NCH-1:0][CH_W-1:0] pix;

    assign w_eff = (32'(image_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : image_width;
    assign h_eff = (32'(image_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : image_height;

    assign status.in_image = (32'(q_col_reg) < 32'(w_eff)) && (32'(q_row_reg) < 32'(h_eff));
    assign status.n_cnt    = (32'(offset_count) > MAX_OFFSETS) ? CNT_W'(MAX_OFFSETS)
                                                               : offset_count;

    assign nx = $signed({2'b00, q_col_reg[COL_W-1:0]}) + (COL_W+2)'(dx_reg[cmd.idx]);
    assign ny = $signed({2'b00, q_row_reg[ROW_W-1:0]}) + (ROW_W+2)'(dy_reg[cmd.idx]);
    assign nbr_inside = !nx[COL_W+1] && (32'(nx[COL_W:0]) < 32'(w_eff))
                     && !ny[ROW_W+1] && (32'(ny[ROW_W:0]) < 32'(h_eff));

    assign rd_en   = cmd.rd_centre || (cmd.rd_nbr && nbr_inside);
    assign rd_addr = cmd.rd_centre ? {q_row_reg[ROW_W-1:0], q_col_reg[COL_W-1:0]}
                                   : {ny[ROW_W-1:0], nx[COL_W-1:0]};
    assign wr_addr = {row[ROW_W-1:0], col[COL_W-1:0]};

    // memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_pix && (32'(col) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT))
            frame_mem[wr_addr] <= {in_ch3, in_ch2, in_ch1, in_ch0};
        if (rd_en)
            rd_data_reg <= frame_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_off && (32'(entry_index) < MAX_OFFSETS))
        begin
            dx_reg[entry_index[IDX_W-1:0]] <= clamp_off(offset_dx);
            dy_reg[entry_index[IDX_W-1:0]] <= clamp_off(offset_dy);
        end
        if (cmd.start_q)
        begin
            q_col_reg <= col;
            q_row_reg <= row;
        end
        acc_reg <= acc_next;
        if (cmd.load_out)
            out_reg <= acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= rd_en;
            rd_first_reg <= cmd.rd_centre;
        end
    end

    always_comb
    begin
        ch_en[0] = 1'b1;
        ch_en[1] = (pixel_format != FMT_GRAY);
        ch_en[2] = (pixel_format != FMT_GRAY);
        ch_en[3] = (pixel_format != FMT_GRAY) && (pixel_format != FMT_RGB);
        for (int c = 0; c < NCH; c++)
            pix[c] = ch_en[c] ? rd_data_reg[c*CH_W +: CH_W] : '0;

        acc_next = acc_reg;
        if (cmd.start_q)
            acc_next = '0;
        else if (rd_vld_reg)
        begin
            if (rd_first_reg)
                acc_next = pix;
            else
            begin
                for (int c = 0; c < NCH; c++)
                begin
                    if (operation_mode ? (pix[c] < acc_reg[c]) : (pix[c] > acc_reg[c]))
                        acc_next[c] = pix[c];
                end
            end
        end
    end

    assign out_ch0 = out_reg[0];
    assign out_ch1 = out_reg[1];
    assign out_ch2 = out_reg[2];
    assign out_ch3 = out_reg[3];

endmodule

### sv/morphology_dilate_erode_engine.sv
// Top level: APB register file, query sequencer and frame-store datapath.
// Writes are taken while idle; opcode 3 is taken and dropped. A query reads the centre
// pixel, then neighbours inside the image for the n offsets in use (up to 32; one frame-store
// read a cycle), and raises its result; outside the image, no frame-store reads are made.
// A waiting result does not block the input; the next query result waits for it.
// Reset clears control state and sets the configuration registers; the stores hold nothing until written.
module morphology_dilate_erode_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  col,
    input  logic [7:0]  row,
    input  logic [4:0]  entry_index,
    input  logic signed [4:0] offset_dx,
    input  logic signed [4:0] offset_dy,
    input  logic [7:0]  in_ch0,
    input  logic [7:0]  in_ch1,
    input  logic [7:0]  in_ch2,
    input  logic [7:0]  in_ch3,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_ch0,
    output logic [7:0]  out_ch1,
    output logic [7:0]  out_ch2,
    output logic [7:0]  out_ch3
);
    import mde_pkg::*;

    logic [DIM_W-1:0] image_width_reg, image_height_reg;
    logic [1:0]       pixel_format_reg;
    logic             operation_mode_reg;
    logic [CNT_W-1:0] offset_count_reg;
    logic             cfg_wr;
    cmd_t             cmd;
    status_t          status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= DIM_W'(256);
            image_height_reg   <= DIM_W'(256);
            pixel_format_reg   <= FMT_GRAY;
            operation_mode_reg <= 1'b0;
            offset_count_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_IMG_W:  image_width_reg    <= pwdata[DIM_W-1:0];
                REG_IMG_H:  image_height_reg   <= pwdata[DIM_W-1:0];
                REG_FORMAT: pixel_format_reg   <= pwdata[1:0];
                REG_MODE:   operation_mode_reg <= pwdata[0];
                REG_OFF_N:  offset_count_reg   <= pwdata[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_IMG_W:  prdata = 32'(image_width_reg);
            REG_IMG_H:  prdata = 32'(image_height_reg);
            REG_FORMAT: prdata = 32'(pixel_format_reg);
            REG_MODE:   prdata = 32'(operation_mode_reg);
            REG_OFF_N:  prdata = 32'(offset_count_reg);
            default:    prdata = '0;
        endcase
    end

    mde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    mde_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .col            (col),
        .row            (row),
        .entry_index    (entry_index),
        .offset_dx      (offset_dx),
        .offset_dy      (offset_dy),
        .in_ch0         (in_ch0),
        .in_ch1         (in_ch1),
        .in_ch2         (in_ch2),
        .in_ch3         (in_ch3),
        .image_width    (image_width_reg),
        .image_height   (image_height_reg),
        .pixel_format   (pixel_format_reg),
        .operation_mode (operation_mode_reg),
        .offset_count   (offset_count_reg),
        .out_ch0        (out_ch0),
        .out_ch1        (out_ch1),
        .out_ch2        (out_ch2),
        .out_ch3        (out_ch3)
    );

endmodule

### sv/mde_checker.sv
// Port-level checks for the morphology engine, bound to the top level.
module mde_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] opcode,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_ch0,
    input logic [7:0] out_ch1,
    input logic [7:0] out_ch2,
    input logic [7:0] out_ch3
);
    import mde_pkg::*;

    // held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_ch0) && $stable(out_ch1)
                                   && $stable(out_ch2) && $stable(out_ch3))
        else $error("result word changed while stalled");

    // a query keeps the input side closed for at least the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_QUERY |=> !in_ready)
        else $error("input taken during a query");

    // writes never raise a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode != OP_QUERY && !out_valid |=> !out_valid)
        else $error("result without a query");

    // a result only appears at the end of a query
    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result raised while idle");

endmodule

bind morphology_dilate_erode_engine mde_checker u_mde_checker (.*);
